// ===== sv/qts_pkg.sv =====
`timescale 1ns / 1ps

package qts_pkg;

    localparam int unsigned MAX_LEN    = 256;
    localparam int unsigned MAX_TOKENS = 16;

    localparam int unsigned POS_CAP_INT   = (MAX_LEN - 1 > 255) ? 255 : (MAX_LEN - 1);
    localparam int unsigned TOKEN_CAP_INT = (MAX_TOKENS > 16) ? 16 : MAX_TOKENS;

    localparam logic [7:0] POS_CAP   = POS_CAP_INT[7:0];
    localparam logic [4:0] TOKEN_CAP = TOKEN_CAP_INT[4:0];

    localparam logic [7:0] SPLIT_CHAR_RST = 8'd32;
    localparam logic [7:0] QUOTE_CHAR_RST = 8'd34;
    localparam logic [4:0] MAX_TOKENS_RST = 5'd8;

    typedef enum logic [1:0] {
        REG_SPLIT_CHAR = 2'd0,
        REG_QUOTE_CHAR = 2'd1,
        REG_MAX_TOKENS = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        ACT_NONE  = 3'd0,
        ACT_START = 3'd1,
        ACT_SPLIT = 3'd2,
        ACT_END   = 3'd3,
        ACT_STOP  = 3'd4
    } action_t;

    typedef struct packed {
        logic [7:0] split_char;
        logic [7:0] quote_char;
        logic [4:0] max_tokens;
    } cfg_t;

    typedef struct packed {
        logic       inside_token;
        logic       inside_quote;
        logic [4:0] tokens_seen;
        logic [7:0] last_split_pos;
        logic [7:0] char_position;
        logic       limit_hit;
    } line_state_t;

    typedef struct packed {
        logic       fully_split;
        logic [4:0] token_count;
        logic [7:0] restore_position;
        logic [3:0] token_number;
        action_t    action;
        logic [7:0] position;
    } result_t;

endpackage

// ===== sv/qts_step.sv =====
`timescale 1ns / 1ps

module qts_step (
    input  qts_pkg::cfg_t        cfg,
    input  qts_pkg::line_state_t state_cur,
    input  logic [7:0]           char_code,
    output qts_pkg::line_state_t state_next,
    output qts_pkg::result_t     result
);

    logic [4:0] limit;
    logic       is_quote;
    logic       is_split;

    always_comb begin
        if (cfg.max_tokens == 5'd0) begin
            limit = 5'd1;
        end else if (cfg.max_tokens > qts_pkg::TOKEN_CAP) begin
            limit = qts_pkg::TOKEN_CAP;
        end else begin
            limit = cfg.max_tokens;
        end
    end

    assign is_quote = (char_code == cfg.quote_char);
    assign is_split = (char_code == cfg.split_char);

    always_comb begin
        state_next                = state_cur;
        result.position           = state_cur.char_position;
        result.action             = qts_pkg::ACT_NONE;
        result.token_number       = 4'd0;
        result.restore_position   = 8'd0;
        result.token_count        = 5'd0;
        result.fully_split        = 1'b0;

        if (char_code == 8'd0) begin
            result.action      = qts_pkg::ACT_END;
            result.token_count = state_cur.tokens_seen;
            result.fully_split = !state_cur.limit_hit;
            state_next         = '0;
        end else begin
            if (!state_cur.limit_hit) begin
                if (state_cur.inside_quote) begin
                    if (is_quote) begin
                        state_next.inside_quote = 1'b0;
                    end
                end else if (state_cur.inside_token && is_quote) begin
                    state_next.inside_quote = 1'b1;
                end else if (state_cur.inside_token && is_split) begin
                    state_next.inside_token   = 1'b0;
                    state_next.last_split_pos = state_cur.char_position;
                    result.action             = qts_pkg::ACT_SPLIT;
                end else if (!state_cur.inside_token && !is_split) begin
                    if (state_cur.tokens_seen >= limit) begin
                        state_next.limit_hit    = 1'b1;
                        result.action           = qts_pkg::ACT_STOP;
                        result.restore_position = state_cur.last_split_pos;
                    end else begin
                        result.action           = qts_pkg::ACT_START;
                        result.token_number     = state_cur.tokens_seen[3:0];
                        state_next.tokens_seen  = state_cur.tokens_seen + 5'd1;
                        state_next.inside_token = 1'b1;
                        if (is_quote) begin
                            state_next.inside_quote = 1'b1;
                        end
                    end
                end
            end
            if (state_cur.char_position < qts_pkg::POS_CAP) begin
                state_next.char_position = state_cur.char_position + 8'd1;
            end
        end
    end

endmodule

// ===== sv/quoted_token_splitter_top.sv =====
`timescale 1ns / 1ps

// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: char_code
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: result fields, tuser: action
// cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
// one result per character, registered and presented in the cycle after the character is taken
// a new character is taken every cycle while the result register drains
// the step logic is combinational; the single result register after it holds each result
// aresetn low clears line state, result valid and restores register defaults
// a stalled m_axis holds its result; s_axis_tready drops only while it is full

module quoted_token_splitter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] position, [11:8] token_number,
                                        // [19:12] restore_position, [24:20] token_count,
                                        // [25] fully_split, [31:26] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] action
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    qts_pkg::cfg_t        cfg_reg;
    qts_pkg::line_state_t state_reg;
    qts_pkg::line_state_t state_next;
    qts_pkg::result_t     result_reg;
    qts_pkg::result_t     result_next;
    logic                 out_valid_reg;
    logic                 in_accept;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    qts_step u_step (
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .char_code  (s_axis_tdata),
        .state_next (state_next),
        .result     (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.split_char <= qts_pkg::SPLIT_CHAR_RST;
            cfg_reg.quote_char <= qts_pkg::QUOTE_CHAR_RST;
            cfg_reg.max_tokens <= qts_pkg::MAX_TOKENS_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                qts_pkg::REG_SPLIT_CHAR: cfg_reg.split_char <= cfg_data;
                qts_pkg::REG_QUOTE_CHAR: cfg_reg.quote_char <= cfg_data;
                qts_pkg::REG_MAX_TOKENS: cfg_reg.max_tokens <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_accept) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            result_reg <= result_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = result_reg.action;
    assign m_axis_tdata  = {6'd0,
                            result_reg.fully_split,
                            result_reg.token_count,
                            result_reg.restore_position,
                            result_reg.token_number,
                            result_reg.position};

    // quote region only exists inside a token
    a_quote_in_token: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.inside_quote |-> state_reg.inside_token)
        else $error("quote open outside a token");

    // a stop leaves no open token
    a_stop_closed: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.limit_hit |-> (!state_reg.inside_token && !state_reg.inside_quote))
        else $error("token still open after stop");

    // token count never passes the hard cap
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.tokens_seen <= qts_pkg::TOKEN_CAP)
        else $error("token count above cap");

    // terminator clears the line
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && s_axis_tdata == 8'd0) |=>
            (state_reg.tokens_seen == 5'd0 && state_reg.char_position == 8'd0
             && !state_reg.limit_hit))
        else $error("line state not cleared at terminator");

endmodule
